// ===== hdl/sorted_set_lists_with_merge_macros.svh =====
// Assertion helpers, included by sslm_core.
`ifndef SORTED_SET_LISTS_WITH_MERGE_MACROS_SVH
`define SORTED_SET_LISTS_WITH_MERGE_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define SSLM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define SSLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sslm_pkg.sv =====
package sslm_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int NUM_LISTS  = 3;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_W     = $clog2(NUM_LISTS * LIST_DEPTH);
    localparam int VAL_W      = 32;
    localparam int POS_W      = 5;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int LCNT_W     = 5;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [1:0] t_lst;
    localparam t_lst LST_ONE   = 2'd0;
    localparam t_lst LST_TWO   = 2'd1;
    localparam t_lst LST_MERGE = 2'd2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_MERGE  = 2'd2
    } t_req_type;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 3'd0,
        STS_DUP    = 3'd1,
        STS_EMPTY  = 3'd2,
        STS_BADPOS = 3'd3,
        STS_FULL   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_DEL_RD,
        S_DEL_WR,
        S_MRG_RD,
        S_MRG_LD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic                    list_sel;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LCNT_W-1:0]   list_count;
    } t_rsp;

    function automatic logic [ADDR_W-1:0] mem_addr(input t_lst lst,
                                                   input logic [IDX_W-1:0] idx);
        return ADDR_W'(lst) * ADDR_W'(LIST_DEPTH) + ADDR_W'(idx);
    endfunction

endpackage

// ===== hdl/sslm_req_if.sv =====
interface sslm_req_if;
    import sslm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic                    list_sel;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;

    modport source (output valid, req_type, list_sel, value, position, input ready);
    modport sink   (input valid, req_type, list_sel, value, position, output ready);
endinterface

// ===== hdl/sslm_rsp_if.sv =====
interface sslm_rsp_if;
    import sslm_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [LCNT_W-1:0]   list_count;

    modport source (output valid, status, list_count, input ready);
    modport sink   (input valid, status, list_count, output ready);
endinterface

// ===== hdl/sslm_core.sv =====
`include "sorted_set_lists_with_merge_macros.svh"

module sslm_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  sslm_pkg::t_req i_req,
    output logic           o_req_ready,
    output logic           o_rsp_valid,
    output sslm_pkg::t_rsp o_rsp,
    input  logic           i_rsp_ready
);
    import sslm_pkg::*;

    // value store: three regions of LIST_DEPTH words
    logic signed [VAL_W-1:0] mem [NUM_LISTS*LIST_DEPTH];
    logic signed [VAL_W-1:0] r_rdata;

    logic [CNT_W-1:0] r_cnt [NUM_LISTS];

    t_state                  r_state, n_state;
    logic [REQ_W-1:0]        r_op, n_op;
    t_lst                    r_lst, n_lst;
    logic signed [VAL_W-1:0] r_v, n_v;
    logic [CNT_W-1:0]        r_i, n_i;
    logic [CNT_W-1:0]        r_n, n_n;
    logic                    r_placed, n_placed;
    t_status                 r_status, n_status;
    logic                    r_src, n_src;
    logic [CNT_W-1:0]        r_k, n_k;
    logic [CNT_W-1:0]        r_src_n, n_src_n;

    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic signed [VAL_W-1:0] mem_wdata;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    cnt_we;

    logic             rd_lt, rd_eq, at_end, is_full, del_last, src_end;
    logic             del_bad, del_empty;
    logic [CNT_W-1:0] in_cnt, i_next;
    logic [CMP_W-1:0] del_pos, del_n;

    always_comb begin
        rd_lt     = r_rdata < r_v;
        rd_eq     = r_rdata == r_v;
        at_end    = r_i == r_n;
        is_full   = r_n == CNT_W'(LIST_DEPTH);
        i_next    = r_i + CNT_W'(1);
        del_last  = ({1'b0, r_i} + (CNT_W+1)'(1)) >= {1'b0, r_n};
        src_end   = r_k == r_src_n;
        in_cnt    = r_cnt[{1'b0, i_req.list_sel}];
        del_pos   = CMP_W'(i_req.position);
        del_n     = CMP_W'(in_cnt);
        del_empty = in_cnt == '0;
        del_bad   = (del_pos == '0) || (del_pos > del_n);
    end

    // next state
    always_comb begin
        t_state ins_exit;
        ins_exit = (r_op == REQ_MERGE) ? S_MRG_RD : S_DONE;
        n_state  = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    unique case (i_req.req_type)
                        REQ_INSERT: n_state = S_INS_RD;
                        REQ_DELETE: n_state = (del_empty || del_bad) ? S_DONE : S_DEL_RD;
                        REQ_MERGE:  n_state = S_MRG_RD;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_INS_RD:  n_state = at_end ? ins_exit : S_INS_CMP;
            S_INS_CMP: begin
                if (!r_placed && (rd_eq || (!rd_lt && is_full))) n_state = ins_exit;
                else n_state = S_INS_RD;
            end
            S_DEL_RD:  n_state = del_last ? S_DONE : S_DEL_WR;
            S_DEL_WR:  n_state = S_DEL_RD;
            S_MRG_RD: begin
                if (src_end) n_state = r_src ? S_DONE : S_MRG_RD;
                else n_state = S_MRG_LD;
            end
            S_MRG_LD:  n_state = S_INS_RD;
            S_DONE:    n_state = i_rsp_ready ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_op      = r_op;
        n_lst     = r_lst;
        n_v       = r_v;
        n_i       = r_i;
        n_n       = r_n;
        n_placed  = r_placed;
        n_status  = r_status;
        n_src     = r_src;
        n_k       = r_k;
        n_src_n   = r_src_n;
        mem_we    = 1'b0;
        mem_waddr = mem_addr(r_lst, r_i[IDX_W-1:0]);
        mem_wdata = r_v;
        rd_en     = 1'b0;
        rd_addr   = mem_addr(r_lst, r_i[IDX_W-1:0]);
        cnt_we    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op     = i_req.req_type;
                    n_v      = i_req.value;
                    n_i      = '0;
                    n_placed = 1'b0;
                    n_status = STS_OK;
                    n_lst    = t_lst'({1'b0, i_req.list_sel});
                    n_n      = in_cnt;
                    unique case (i_req.req_type)
                        REQ_INSERT: ;
                        REQ_DELETE: begin
                            if (del_empty) n_status = STS_EMPTY;
                            else if (del_bad) n_status = STS_BADPOS;
                            else n_i = CNT_W'(i_req.position - POS_W'(1));
                        end
                        REQ_MERGE: begin
                            n_lst   = LST_MERGE;
                            n_n     = r_cnt[LST_MERGE];
                            n_src   = 1'b0;
                            n_k     = '0;
                            n_src_n = r_cnt[LST_ONE];
                        end
                        default: ;
                    endcase
                end
            end
            S_INS_RD: begin
                if (at_end) begin
                    // append the new value or the last carried element
                    if (r_placed || !is_full) begin
                        mem_we = 1'b1;
                        n_n    = r_n + CNT_W'(1);
                        cnt_we = 1'b1;
                    end else begin
                        n_status = STS_FULL;
                    end
                end else begin
                    rd_en = 1'b1;
                end
            end
            S_INS_CMP: begin
                if (!r_placed) begin
                    if (rd_eq) begin
                        if (r_op != REQ_MERGE) n_status = STS_DUP;
                    end else if (rd_lt) begin
                        n_i = i_next;
                    end else if (is_full) begin
                        n_status = STS_FULL;
                    end else begin
                        mem_we   = 1'b1;
                        n_v      = r_rdata;
                        n_placed = 1'b1;
                        n_i      = i_next;
                    end
                end else begin
                    // ripple the tail up by one slot
                    mem_we = 1'b1;
                    n_v    = r_rdata;
                    n_i    = i_next;
                end
            end
            S_DEL_RD: begin
                if (del_last) begin
                    n_n    = r_n - CNT_W'(1);
                    cnt_we = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = mem_addr(r_lst, i_next[IDX_W-1:0]);
                end
            end
            S_DEL_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_rdata;
                n_i       = i_next;
            end
            S_MRG_RD: begin
                if (src_end) begin
                    if (!r_src) begin
                        n_src   = 1'b1;
                        n_k     = '0;
                        n_src_n = r_cnt[LST_TWO];
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = mem_addr(t_lst'({1'b0, r_src}), r_k[IDX_W-1:0]);
                end
            end
            S_MRG_LD: begin
                n_v      = r_rdata;
                n_k      = r_k + CNT_W'(1);
                n_i      = '0;
                n_placed = 1'b0;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_comb begin
        o_req_ready      = r_state == S_IDLE;
        o_rsp_valid      = r_state == S_DONE;
        o_rsp.status     = r_status;
        o_rsp.list_count = LCNT_W'(r_n);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int j = 0; j < NUM_LISTS; j++) begin
                r_cnt[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (cnt_we) begin
                r_cnt[r_lst] <= n_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_lst    <= n_lst;
        r_v      <= n_v;
        r_i      <= n_i;
        r_n      <= n_n;
        r_placed <= n_placed;
        r_status <= n_status;
        r_src    <= n_src;
        r_k      <= n_k;
        r_src_n  <= n_src_n;
    end

    `SSLM_ASSERT_NEXT(a_accept_leaves_idle, i_req_valid && o_req_ready,
        r_state != S_IDLE, "accepted request did not start")
    `SSLM_ASSERT_NOW(a_ripple_has_room, (r_state == S_INS_CMP) && r_placed,
        (r_n < CNT_W'(LIST_DEPTH)) && (r_i < r_n), "tail shift past list end")
    `SSLM_ASSERT_NEXT(a_merge_keeps_sources, (r_op == REQ_MERGE) && (r_state != S_IDLE),
        $stable(r_cnt[LST_ONE]) && $stable(r_cnt[LST_TWO]), "merge changed a source list")
    `SSLM_ASSERT_NOW(a_delete_status, (r_state == S_DONE) && (r_op == REQ_DELETE),
        (r_status == STS_OK) || (r_status == STS_EMPTY) || (r_status == STS_BADPOS),
        "bad delete status")

endmodule

// ===== hdl/sorted_set_lists_with_merge.sv =====
// Sorted set store: list one, list two and a merge list, each up to LIST_DEPTH
// signed 32-bit values kept ascending and duplicate-free.
// i_req: request channel (valid/ready). req_type 0 inserts value into the list
// picked by list_sel, 1 deletes the 1-based position there, 2 merges lists one
// and two into the merge list (accumulating, duplicates skipped silently).
// o_rsp: one response per request: status and the affected list's count.
// One request at a time; i_req.ready is high only while the sequencer is idle.
// A single-port value memory with registered read is walked one element at a
// time: an insert reads then compares each element, a delete reads then writes
// each moved element, and a merge loads each source element before inserting it.
// An error or unused request type goes straight to the response.
// The response sits in an output register; the next request is taken while it
// waits. If o_rsp stalls with a result already held, the sequencer holds its
// own finished result until the register frees up.
// Reset (synchronous, active low) empties all three lists at once; no memory
// sweep is needed since entries past a list's count are never read.
module sorted_set_lists_with_merge (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sslm_req_if.sink    i_req,
    sslm_rsp_if.source  o_rsp
);
    import sslm_pkg::*;

    t_req req;
    t_rsp core_rsp;
    t_rsp r_out;
    logic core_ready;
    logic core_rsp_valid;
    logic core_rsp_ready;
    logic r_out_valid;

    always_comb begin
        req.req_type = i_req.req_type;
        req.list_sel = i_req.list_sel;
        req.value    = i_req.value;
        req.position = i_req.position;
    end

    assign i_req.ready    = core_ready;
    assign core_rsp_ready = !r_out_valid || o_rsp.ready;

    sslm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req       (req),
        .o_req_ready (core_ready),
        .o_rsp_valid (core_rsp_valid),
        .o_rsp       (core_rsp),
        .i_rsp_ready (core_rsp_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_rsp_ready) begin
            r_out_valid <= core_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_rsp_ready && core_rsp_valid) begin
            r_out <= core_rsp;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.list_count = r_out.list_count;

endmodule

// ===== tb/sv/sslm_set_compare.sv =====
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the three sorted sets and
// checks each response against the oldest outstanding prediction.
module sslm_set_compare (
    input  logic i_clk,
    input  logic i_rst_n,
    sslm_req_if  i_req,
    sslm_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_reject_count
);
    import sslm_pkg::*;

    localparam int REPORT_MAX = 10;

    logic signed [VAL_W-1:0] set_vals [NUM_LISTS][LIST_DEPTH];
    int                      set_cnt  [NUM_LISTS];
    t_rsp                    awaited_rsp [$];
    int                      fails    = 0;
    int                      checked  = 0;
    int                      rejects  = 0;

    function automatic t_status set_add(input int lst, input logic signed [VAL_W-1:0] v);
        int slot;
        int k;
        slot = 0;
        while (slot < set_cnt[lst] && set_vals[lst][slot] < v) slot++;
        if (slot < set_cnt[lst] && set_vals[lst][slot] == v) return STS_DUP;
        if (set_cnt[lst] >= LIST_DEPTH) return STS_FULL;
        for (k = set_cnt[lst]; k > slot; k--) set_vals[lst][k] = set_vals[lst][k-1];
        set_vals[lst][slot] = v;
        set_cnt[lst]++;
        return STS_OK;
    endfunction

    function automatic t_status set_drop(input int lst, input int pos);
        int k;
        if (set_cnt[lst] == 0) return STS_EMPTY;
        if (pos == 0 || pos > set_cnt[lst]) return STS_BADPOS;
        for (k = pos - 1; k + 1 < set_cnt[lst]; k++) set_vals[lst][k] = set_vals[lst][k+1];
        set_cnt[lst]--;
        return STS_OK;
    endfunction

    // Applies one request to the shadow sets and returns the response it should give.
    function automatic t_rsp apply_request(input logic [REQ_W-1:0] rt, input logic sel,
                                           input logic signed [VAL_W-1:0] v,
                                           input logic [POS_W-1:0] pos);
        t_rsp    r;
        t_status st;
        int      lst;
        int      src;
        int      k;
        st  = STS_OK;
        lst = int'(sel);
        case (rt)
            REQ_INSERT: st = set_add(lst, v);
            REQ_DELETE: st = set_drop(lst, int'(pos));
            REQ_MERGE: begin
                lst = int'(LST_MERGE);
                // list one first, then list two; duplicates are skipped quietly
                for (src = int'(LST_ONE); src <= int'(LST_TWO); src++) begin
                    for (k = 0; k < set_cnt[src]; k++) begin
                        if (set_add(int'(LST_MERGE), set_vals[src][k]) == STS_FULL)
                            st = STS_FULL;
                    end
                end
            end
            default: ;
        endcase
        r.status     = st;
        r.list_count = LCNT_W'(set_cnt[lst]);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            set_cnt = '{default: 0};
            awaited_rsp.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                checked++;
                if (i_rsp.status != STS_OK) rejects++;
                if (awaited_rsp.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("unexpected response: status %0d count %0d",
                                 i_rsp.status, i_rsp.list_count);
                end else begin
                    want = awaited_rsp.pop_front();
                    if (i_rsp.status != want.status ||
                        i_rsp.list_count != want.list_count) begin
                        fails++;
                        if (fails <= REPORT_MAX)
                            $display({"mismatch: expected status %0d count %0d,",
                                      " got status %0d count %0d"},
                                     want.status, want.list_count,
                                     i_rsp.status, i_rsp.list_count);
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                awaited_rsp.push_back(apply_request(i_req.req_type, i_req.list_sel,
                                                    i_req.value, i_req.position));
        end
        o_fail_count   <= fails;
        o_pending      <= awaited_rsp.size();
        o_checked      <= checked;
        o_reject_count <= rejects;
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sslm_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 1450;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLDOFF_AT     = 3000;
    localparam int HOLDOFF_LEN    = 400;

    logic clk = 1'b0;
    logic rst_n;

    sslm_req_if req_bus ();
    sslm_rsp_if rsp_bus ();

    int fail_count;
    int pending;
    int checked;
    int reject_count;
    int stall_cycles = 0;
    int n_insert = 0;
    int n_delete = 0;
    int n_merge  = 0;
    int n_unused = 0;
    bit src_gaps = 1'b1;

    sorted_set_lists_with_merge u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    sslm_set_compare u_compare (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req          (req_bus),
        .i_rsp          (rsp_bus),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_reject_count (reject_count)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hands one request to the block; returns at the edge where it is taken.
    task automatic push_req(input logic [REQ_W-1:0] rt, input logic sel,
                            input logic [VAL_W-1:0] v, input logic [POS_W-1:0] pos);
        while (src_gaps && $urandom_range(0, 99) < 24) begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= rt;
        req_bus.list_sel <= sel;
        req_bus.value    <= v;
        req_bus.position <= pos;
        case (rt)
            REQ_INSERT: n_insert++;
            REQ_DELETE: n_delete++;
            REQ_MERGE:  n_merge++;
            default:    n_unused++;
        endcase
        @(posedge clk);
        while (!req_bus.ready) @(posedge clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        // a narrow pool makes duplicates and full lists common
        if (roll < 60) return VAL_W'($urandom_range(0, 20)) - VAL_W'(10);
        if (roll < 75) begin
            case ($urandom_range(0, 5))
                0:       return 32'h8000_0000;
                1:       return 32'h8000_0001;
                2:       return 32'h7fff_ffff;
                3:       return 32'h7fff_fffe;
                4:       return 32'hffff_ffff;
                default: return 32'h0000_0000;
            endcase
        end
        return VAL_W'($urandom);
    endfunction

    // Receiver: random stalls, one quiet stretch, one long hold-off.
    initial begin : sink_side
        int cyc;
        cyc = 0;
        rsp_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            cyc++;
            if (cyc == HOLDOFF_AT) begin
                rsp_bus.ready <= 1'b0;
                repeat (HOLDOFF_LEN) @(posedge clk);
                cyc += HOLDOFF_LEN;
            end
            if (cyc >= 6000 && cyc < 9000)
                rsp_bus.ready <= 1'b1;
            else
                rsp_bus.ready <= ($urandom_range(0, 99) >= 24);
        end
    end

    always @(posedge clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                     stall_cycles, pending);
            $display("** sorted_set_lists_with_merge: FAILED **");
            $finish;
        end
    end

    initial begin : source_side
        int k;
        int n;
        int roll;
        int ins_pct;
        int del_pct;
        logic [REQ_W-1:0] rt;
        logic [POS_W-1:0] pos;

        rst_n            <= 1'b0;
        req_bus.valid    <= 1'b0;
        req_bus.req_type <= REQ_INSERT;
        req_bus.list_sel <= 1'b0;
        req_bus.value    <= '0;
        req_bus.position <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, extremes, bad positions, full list, merge overflow
        push_req(REQ_DELETE, 1'b0, '0, POS_W'(1));
        push_req(REQ_MERGE,  1'b0, '0, '0);
        push_req(REQ_UNUSED, 1'b1, '1, '1);
        push_req(REQ_INSERT, 1'b0, 32'h8000_0000, '0);
        push_req(REQ_INSERT, 1'b0, 32'h7fff_ffff, '0);
        push_req(REQ_INSERT, 1'b0, 32'h7fff_ffff, '0);
        push_req(REQ_DELETE, 1'b0, '0, POS_W'(0));
        push_req(REQ_DELETE, 1'b0, '0, POS_W'(31));
        push_req(REQ_DELETE, 1'b0, '0, POS_W'(3));
        push_req(REQ_DELETE, 1'b0, '0, POS_W'(1));
        // out-of-order fill of list two, -8..7
        for (k = 0; k < LIST_DEPTH; k++)
            push_req(REQ_INSERT, 1'b1, VAL_W'((k * 7) % 16 - 8), '0);
        push_req(REQ_INSERT, 1'b1, VAL_W'(100), '0);
        push_req(REQ_INSERT, 1'b1, VAL_W'(0), '0);
        push_req(REQ_MERGE,  1'b0, '0, '0);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            src_gaps = !(n >= 400 && n < 700);
            // alternate fill-heavy, drain-heavy and mixed phases
            case ((n / 120) % 3)
                0:       begin ins_pct = 70; del_pct = 20; end
                1:       begin ins_pct = 25; del_pct = 65; end
                default: begin ins_pct = 48; del_pct = 40; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)                    rt = REQ_INSERT;
            else if (roll < ins_pct + del_pct)     rt = REQ_DELETE;
            else if (roll < 96)                    rt = REQ_MERGE;
            else                                   rt = REQ_UNUSED;
            if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, 17));
            else                            pos = POS_W'($urandom_range(0, 31));
            push_req(rt, 1'($urandom_range(0, 1)), pick_value(), pos);
        end
        req_bus.valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (50) @(posedge clk);

        $display("Ran %0d requests: %0d inserts, %0d deletes, %0d merges, %0d unused type",
                 n_insert + n_delete + n_merge + n_unused,
                 n_insert, n_delete, n_merge, n_unused);
        $display("%0d responses compared, %0d carried a non-ok status", checked, reject_count);
        if (fail_count == 0) begin
            $display("** sorted_set_lists_with_merge: PASSED **");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("** sorted_set_lists_with_merge: FAILED **");
        end
        $finish;
    end

endmodule
